// File: sv/hkpt_pkg.sv
// Shared types, widths and codes for the half-space kernel point test.
// No dependencies; imported by every module of the block.
package hkpt_pkg;

  localparam int COORD_W = 32;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int RAD_W   = 64;  // radicand of the square root
  localparam int ROOT_W  = 31;  // root of a radicand below 2^62
  localparam int NUM_W   = 61;  // dividend: magnitude * 2^30 + root / 2
  localparam int QUO_W   = 31;  // quotient never exceeds 2^30

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t nx;
    coord_t ny;
    coord_t nz;
  } plane_t;

  localparam logic [REQ_W-1:0] REQ_V0    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_V1    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_V2    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REF   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_JUDGE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_DEGEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

  localparam logic [0:0] CFG_MARGIN = 1'b0;
  localparam logic [0:0] CFG_MINLEN = 1'b1;

  // Difference a - b clamped to the signed 32-bit range.
  function automatic coord_t sat_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    coord_t r;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (d[COORD_W] != d[COORD_W-1]) begin
      r = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = d[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/hkpt_plane_mem.sv
// Plane table: one row holds origin and unit normal of a stored constraint.
// Synchronous write, registered read. Uses hkpt_pkg.
module hkpt_plane_mem import hkpt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  plane_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output plane_t        rdata_o
);

  plane_t mem_q [DEPTH];
  plane_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hkpt_isqrt.sv
// Floor square root, two radicand bits per cycle.
// Uses hkpt_pkg for widths.
module hkpt_isqrt import hkpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0] s_q, s_d, r_q, r_d, bit_q, trial;
  logic             done_q;

  always_comb begin
    trial = r_q + bit_q;
    if (s_q >= trial) begin
      s_d = s_q - trial;
      r_d = (r_q >> 1) + bit_q;
    end else begin
      s_d = s_q;
      r_d = r_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        bit_q <= RAD_W'(1) << (RAD_W - 2);
      end else if (bit_q != '0) begin
        bit_q <= bit_q >> 2;
        if (bit_q == RAD_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q <= rad_i;
      r_q <= '0;
    end else if (bit_q != '0) begin
      s_q <= s_d;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

// File: sv/hkpt_div.sv
// Restoring divider, one quotient bit per cycle.
// The quotient is known to fit QUO_W bits. Uses hkpt_pkg.
module hkpt_div import hkpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int CW = $clog2(QUO_W + 1);

  logic [ROOT_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0]  nlo_q, quo_q;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [ROOT_W:0]   trial;
  logic              qbit;

  always_comb begin
    trial = {rem_q, nlo_q[QUO_W-1]};
    qbit  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(QUO_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= ROOT_W'(num_i[NUM_W-1:QUO_W]);
      nlo_q <= num_i[QUO_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= qbit ? ROOT_W'(trial - {1'b0, den_q}) : trial[ROOT_W-1:0];
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: sv/halfspace_kernel_point_test_core.sv
// Half-space kernel point test, top level: control sequencer and datapath.
// Uses hkpt_pkg, hkpt_plane_mem, hkpt_isqrt and hkpt_div.
//
// Usage: items enter on the in channel (valid/ready), one result beat leaves on the
// out channel for every item. Types 0-2 latch triangle vertices, 3 latches the
// reference point and commits a plane, 4 judges a point, 5 clears the set.
// Configuration (margin, minimum normal length) is written through cfg_we_i only
// while idle: the user must keep to this, the block itself does not enforce it.
// Vertex, clear and rejected items pass through the finish state to the output
// register. In a judge the plane table is read one row per cycle and the rows flow
// through a four-stage diff / multiply / sum / compare pipe. A commit runs the
// one-bit-per-cycle normalizing shift, the square root and three divisions.
// One item is worked on at a time; in_ready_o is high whenever the sequencer is
// free, even while a finished result still waits in the output register.
// When the receiver stalls, the next result holds in its stage until the output
// register drains. Reset empties the set, marks it good, zeroes the pending
// vertices and loads margin 0 and minimum length 1; the plane table is not cleared.
module halfspace_kernel_point_test_core import hkpt_pkg::*; #(
  parameter int MAX_CONSTRAINTS = 64,
  localparam int CNT_W = $clog2(MAX_CONSTRAINTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  coord_t             coord_x_i,
  input  coord_t             coord_y_i,
  input  coord_t             coord_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               inside_res_o,
  output logic               set_is_good_o,
  output logic [CNT_W-1:0]   constraint_total_o,
  output logic [STAT_W-1:0]  status_o
);

  localparam int AW = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIFF = 5'd1;
  localparam logic [4:0] S_CR1  = 5'd2;
  localparam logic [4:0] S_CR2  = 5'd3;
  localparam logic [4:0] S_CR3  = 5'd4;
  localparam logic [4:0] S_MAX  = 5'd5;
  localparam logic [4:0] S_NORM = 5'd6;
  localparam logic [4:0] S_SQ   = 5'd7;
  localparam logic [4:0] S_SUM  = 5'd8;
  localparam logic [4:0] S_SQRT = 5'd9;
  localparam logic [4:0] S_DEG  = 5'd10;
  localparam logic [4:0] S_DIV  = 5'd11;
  localparam logic [4:0] S_DIVW = 5'd12;
  localparam logic [4:0] S_DOT  = 5'd13;
  localparam logic [4:0] S_DOT2 = 5'd14;
  localparam logic [4:0] S_JRUN = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;

  logic [4:0] state_q, state_d;

  // configuration
  coord_t      margin_q;
  logic [30:0] minlen_q;

  // set state
  coord_t           pv_q [12];
  logic [CNT_W-1:0] cnt_q;
  logic             good_q;

  // commit datapath
  coord_t             pt_q [3];
  coord_t             a_q [3], b_q [3], r_q [3], n_q [3];
  logic signed [63:0] pa_q [3], prod_q [3];
  logic [63:0]        m_q [3];
  logic               neg_q [3];
  logic [63:0]        mx_q;
  logic signed [6:0]  e_q;
  logic [ROOT_W-1:0]  root_q;
  logic [1:0]         idx_q;

  // judge pipe
  logic [CNT_W-1:0]   jaddr_q;
  logic               rv_q, dv_q, mv_q, sv_q, fail_q;
  coord_t             jd_q [3], jn_q [3];
  logic signed [63:0] dot_q;

  // result staging and output register
  logic              res_inside_q;
  logic [STAT_W-1:0] res_status_q;
  logic              out_valid_q, out_inside_q, out_good_q;
  logic [CNT_W-1:0]  out_total_q;
  logic [STAT_W-1:0] out_status_q;

  logic in_fire, out_load;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == S_FIN) & (!out_valid_q | out_ready_i);

  // shared multipliers
  coord_t mul_a [3], mul_b [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_a[i] = jn_q[i];
      mul_b[i] = jd_q[i];
    end
    unique case (state_q)
      S_CR1: begin
        mul_a[0] = a_q[1]; mul_b[0] = b_q[2];
        mul_a[1] = a_q[2]; mul_b[1] = b_q[0];
        mul_a[2] = a_q[0]; mul_b[2] = b_q[1];
      end
      S_CR2: begin
        mul_a[0] = a_q[2]; mul_b[0] = b_q[1];
        mul_a[1] = a_q[0]; mul_b[1] = b_q[2];
        mul_a[2] = a_q[1]; mul_b[2] = b_q[0];
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = coord_t'(m_q[i][31:0]);
          mul_b[i] = coord_t'(m_q[i][31:0]);
        end
      end
      S_DOT: begin
        for (int i = 0; i < 3; i++) begin
          mul_a[i] = n_q[i];
          mul_b[i] = r_q[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      prod_q[i] <= mul_a[i] * mul_b[i];
    end
  end

  // cross product components and magnitudes
  logic signed [64:0] cr [3];
  logic [63:0]        cmag [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]   = {pa_q[i][63], pa_q[i]} - {prod_q[i][63], prod_q[i]};
      cmag[i] = cr[i][64] ? 64'(-cr[i]) : cr[i][63:0];
    end
  end

  logic [63:0] mx01, mx_new;
  assign mx01   = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
  assign mx_new = (mx01 > m_q[2]) ? mx01 : m_q[2];

  // degeneracy test against the scaled minimum length
  logic signed [7:0] ediff;
  logic [7:0]        kneg;
  logic              degen;
  always_comb begin
    ediff = {e_q[6], e_q} - 8'sd16;
    kneg  = 8'(-ediff);
    if (minlen_q == '0) begin
      degen = 1'b0;
    end else if (!ediff[7]) begin
      degen = ((64'(root_q) << ediff[5:0]) < 64'(minlen_q));
    end else if (kneg >= 8'd32) begin
      degen = 1'b1;
    end else begin
      degen = (64'(root_q) < (64'(minlen_q) << kneg[4:0]));
    end
  end

  // square root and divider
  logic              sqrt_done, div_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [QUO_W-1:0]  div_quo;
  logic [RAD_W-1:0]  rad;
  logic [63:0]       m_sel;
  logic [NUM_W-1:0]  div_num;

  assign rad = RAD_W'(prod_q[0]) + RAD_W'(prod_q[1]) + RAD_W'(prod_q[2]);

  always_comb begin
    unique case (idx_q)
      2'd0:    m_sel = m_q[0];
      2'd1:    m_sel = m_q[1];
      default: m_sel = m_q[2];
    endcase
  end
  assign div_num = (NUM_W'(m_sel[29:0]) << 30) + NUM_W'(root_q >> 1);

  hkpt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SUM),
    .rad_i   (rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  hkpt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV),
    .num_i   (div_num),
    .den_i   (root_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // plane table
  logic   mem_we, mem_re, flip;
  plane_t mem_wdata, mem_rdata;
  logic signed [63:0] odot, lim;

  assign odot  = prod_q[0] + prod_q[1] + prod_q[2];
  assign flip  = odot[63];
  assign lim   = {{2{margin_q[31]}}, margin_q, 30'b0};
  assign mem_we = (state_q == S_DOT2);
  assign mem_re = (state_q == S_JRUN) && (jaddr_q < cnt_q);

  always_comb begin
    mem_wdata.ox = pv_q[0];
    mem_wdata.oy = pv_q[1];
    mem_wdata.oz = pv_q[2];
    mem_wdata.nx = flip ? -n_q[0] : n_q[0];
    mem_wdata.ny = flip ? -n_q[1] : n_q[1];
    mem_wdata.nz = flip ? -n_q[2] : n_q[2];
  end

  hkpt_plane_mem #(
    .DEPTH (MAX_CONSTRAINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (jaddr_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type_i == REQ_REF && good_q && cnt_q < CNT_W'(MAX_CONSTRAINTS)) begin
            state_d = S_DIFF;
          end else if (req_type_i == REQ_JUDGE && good_q && cnt_q != '0) begin
            state_d = S_JRUN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DIFF: state_d = S_CR1;
      S_CR1:  state_d = S_CR2;
      S_CR2:  state_d = S_CR3;
      S_CR3:  state_d = S_MAX;
      S_MAX:  state_d = (mx_new == '0) ? S_FIN : S_NORM;
      S_NORM: begin
        if (mx_q < 64'h2000_0000 || mx_q >= 64'h4000_0000) begin
          state_d = S_NORM;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ:   state_d = S_SUM;
      S_SUM:  state_d = S_SQRT;
      S_SQRT: state_d = sqrt_done ? S_DEG : S_SQRT;
      S_DEG:  state_d = degen ? S_FIN : S_DIV;
      S_DIV:  state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_d = (idx_q == 2'd2) ? S_DOT : S_DIV;
        end
      end
      S_DOT:  state_d = S_DOT2;
      S_DOT2: state_d = S_FIN;
      S_JRUN: begin
        if (jaddr_q == cnt_q && !rv_q && !dv_q && !mv_q && !sv_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN:  state_d = out_load ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      margin_q    <= '0;
      minlen_q    <= 31'd1;
      cnt_q       <= '0;
      good_q      <= 1'b1;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      dv_q        <= 1'b0;
      mv_q        <= 1'b0;
      sv_q        <= 1'b0;
      for (int i = 0; i < 12; i++) begin
        pv_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MARGIN: margin_q <= cfg_data_i;
          default:    minlen_q <= cfg_data_i[30:0];
        endcase
      end
      if (in_fire) begin
        for (int s = 0; s < 4; s++) begin
          if (req_type_i == REQ_W'(s)) begin
            pv_q[s*3]     <= coord_x_i;
            pv_q[s*3 + 1] <= coord_y_i;
            pv_q[s*3 + 2] <= coord_z_i;
          end
        end
        if (req_type_i == REQ_CLEAR) begin
          cnt_q  <= '0;
          good_q <= 1'b1;
        end else if (req_type_i == REQ_REF && good_q &&
                     cnt_q >= CNT_W'(MAX_CONSTRAINTS)) begin
          good_q <= 1'b0;
        end
      end
      if ((state_q == S_MAX && mx_new == '0) || (state_q == S_DEG && degen)) begin
        good_q <= 1'b0;
      end
      if (state_q == S_DOT2) begin
        cnt_q <= cnt_q + 1'b1;
      end
      rv_q <= mem_re;
      dv_q <= rv_q;
      mv_q <= dv_q;
      sv_q <= mv_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        pt_q[0]      <= coord_x_i;
        pt_q[1]      <= coord_y_i;
        pt_q[2]      <= coord_z_i;
        jaddr_q      <= '0;
        fail_q       <= 1'b0;
        res_inside_q <= 1'b0;
        res_status_q <= ST_OK;
        if (req_type_i == REQ_REF) begin
          if (!good_q) begin
            res_status_q <= ST_BAD;
          end else if (cnt_q >= CNT_W'(MAX_CONSTRAINTS)) begin
            res_status_q <= ST_FULL;
          end
        end else if (req_type_i == REQ_JUDGE) begin
          if (!good_q) begin
            res_status_q <= ST_BAD;
          end else begin
            res_inside_q <= (cnt_q == '0);
          end
        end
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          a_q[i] <= sat_diff(pv_q[3 + i], pv_q[i]);
          b_q[i] <= sat_diff(pv_q[6 + i], pv_q[i]);
          r_q[i] <= sat_diff(pv_q[9 + i], pv_q[i]);
        end
      end
      S_CR2: begin
        for (int i = 0; i < 3; i++) begin
          pa_q[i] <= prod_q[i];
        end
      end
      S_CR3: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= cmag[i];
          neg_q[i] <= cr[i][64];
        end
      end
      S_MAX: begin
        mx_q <= mx_new;
        e_q  <= '0;
        if (mx_new == '0) begin
          res_status_q <= ST_DEGEN;
        end
      end
      S_NORM: begin
        // shift all magnitudes together so the largest lands in [2^29, 2^30)
        if (mx_q >= 64'h4000_0000) begin
          mx_q <= mx_q >> 1;
          e_q  <= e_q + 7'sd1;
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= m_q[i] >> 1;
          end
        end else if (mx_q < 64'h2000_0000) begin
          mx_q <= mx_q << 1;
          e_q  <= e_q - 7'sd1;
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          root_q <= sqrt_root;
        end
      end
      S_DEG: begin
        idx_q <= 2'd0;
        if (degen) begin
          res_status_q <= ST_DEGEN;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          for (int i = 0; i < 3; i++) begin
            if (idx_q == 2'(i)) begin
              n_q[i] <= neg_q[i] ? -coord_t'({1'b0, div_quo}) : coord_t'({1'b0, div_quo});
            end
          end
          idx_q <= idx_q + 2'd1;
        end
      end
      S_JRUN: begin
        if (mem_re) begin
          jaddr_q <= jaddr_q + 1'b1;
        end
        if (sv_q && dot_q < lim) begin
          fail_q <= 1'b1;
        end
        if (state_d == S_FIN) begin
          res_inside_q <= !(fail_q || (sv_q && dot_q < lim));
        end
      end
      default: begin
      end
    endcase
    // judge pipe: row -> clamped diffs -> products -> dot
    jd_q[0] <= sat_diff(pt_q[0], mem_rdata.ox);
    jd_q[1] <= sat_diff(pt_q[1], mem_rdata.oy);
    jd_q[2] <= sat_diff(pt_q[2], mem_rdata.oz);
    jn_q[0] <= mem_rdata.nx;
    jn_q[1] <= mem_rdata.ny;
    jn_q[2] <= mem_rdata.nz;
    dot_q   <= odot;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_inside_q <= res_inside_q;
      out_good_q   <= good_q;
      out_total_q  <= cnt_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign inside_res_o       = out_inside_q;
  assign set_is_good_o      = out_good_q;
  assign constraint_total_o = out_total_q;
  assign status_o           = out_status_q;

endmodule
